// ===== hdl/btr_pkg.sv =====
`timescale 1ns / 1ps

package btr_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  localparam logic [31:0] WINDOW_SIZE = 32'h0000_0030;
  localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

  localparam logic [31:0] OFS_CTRL1  = 32'h00;
  localparam logic [31:0] OFS_CTRL2  = 32'h04;
  localparam logic [31:0] OFS_SMODE  = 32'h08;
  localparam logic [31:0] OFS_IEN    = 32'h0C;
  localparam logic [31:0] OFS_STATUS = 32'h10;
  localparam logic [31:0] OFS_EVGEN  = 32'h14;
  localparam logic [31:0] OFS_COUNT  = 32'h24;
  localparam logic [31:0] OFS_PRESC  = 32'h28;
  localparam logic [31:0] OFS_RELOAD = 32'h2C;

  // bus bit positions of the update and trigger flags
  localparam int unsigned BUS_UPDATE_BIT  = 0;
  localparam int unsigned BUS_TRIGGER_BIT = 6;

  // internal flag positions
  localparam int unsigned FLAG_UPDATE  = 0;
  localparam int unsigned FLAG_TRIGGER = 1;

endpackage

// ===== hdl/btr_in_if.sv =====
`timescale 1ns / 1ps

interface btr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] addr;
  logic [31:0] wdata;

  modport source (output valid, func, addr, wdata, input ready);
  modport sink (input valid, func, addr, wdata, output ready);
endinterface

// ===== hdl/btr_out_if.sv =====
`timescale 1ns / 1ps

interface btr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rdata;
  logic        irq_pending;
  logic [31:0] update_events;

  modport source (output valid, rdata, irq_pending, update_events, input ready);
  modport sink (input valid, rdata, irq_pending, update_events, output ready);
endinterface

// ===== hdl/basic_timer_register_block_core.sv =====
`timescale 1ns / 1ps

// Basic up-counting timer behind a 0x30-byte register window at BASE_ADDR.
// Every input item is a tick, a register read, a register write or the unused
// code, and each one yields exactly one result item carrying read data (zero
// for ticks, writes and the unused code, all ones outside the window or at
// an unmapped offset), the interrupt line (update flag AND update enable)
// and the wrapping count of update events, all sampled after the item has
// acted. Throughput is one item per clock: the state update and the result
// are computed in a single pass of logic (one 32-bit compare per counter and
// one incrementer each) and land in the timer registers and the result
// register at the same edge. The result register doubles as the output
// stage, so a new item is taken whenever that register is empty or is
// being drained in the same cycle. Register map (byte offsets): 0x00
// control one (bit 0 counter enable), 0x04 control two, 0x08 slave mode,
// 0x0C interrupt enable (bit 0 update enable), 0x10 status (bit 0 update
// flag, bit 6 trigger flag, write one to clear), 0x14 event generation
// (bit 0 sets update flag, bit 6 sets trigger flag, reads zero), 0x24
// counter, 0x28 prescaler (divide by value+1), 0x2C auto-reload.

module basic_timer_register_block_core #(
  parameter logic [31:0] BASE_ADDR = 32'h4000_1000
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  btr_in_if.sink     in_i,
  btr_out_if.source  out_o
);
  import btr_pkg::*;

  // timer state
  logic [31:0] ctrl1_q, ctrl1_d;
  logic [31:0] ctrl2_q, ctrl2_d;
  logic [31:0] smode_q, smode_d;
  logic [31:0] ien_q, ien_d;
  logic [1:0]  flags_q, flags_d;
  logic [31:0] count_q, count_d;
  logic [31:0] presc_q, presc_d;
  logic [31:0] reload_q, reload_d;
  logic [31:0] pcount_q, pcount_d;
  logic [31:0] events_q, events_d;

  // result register
  logic        out_valid_q;
  logic [31:0] rdata_q, rdata_d;
  logic        irq_q;

  logic        acc;
  logic [31:0] offset;
  logic        in_window;
  func_e       func;
  logic [31:0] rd_val;
  logic [31:0] wdata;

  // take a new item when the result slot is free or emptying now
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;
  assign func       = func_e'(in_i.func);
  assign wdata      = in_i.wdata;
  assign offset     = in_i.addr - BASE_ADDR;
  assign in_window  = (in_i.addr >= BASE_ADDR) && (offset < WINDOW_SIZE);

  // read mux on the current register contents
  always_comb begin
    case (offset)
      OFS_CTRL1:  rd_val = ctrl1_q;
      OFS_CTRL2:  rd_val = ctrl2_q;
      OFS_SMODE:  rd_val = smode_q;
      OFS_IEN:    rd_val = ien_q;
      OFS_STATUS: begin
        rd_val = '0;
        rd_val[BUS_UPDATE_BIT]  = flags_q[FLAG_UPDATE];
        rd_val[BUS_TRIGGER_BIT] = flags_q[FLAG_TRIGGER];
      end
      OFS_EVGEN:  rd_val = '0;
      OFS_COUNT:  rd_val = count_q;
      OFS_PRESC:  rd_val = presc_q;
      OFS_RELOAD: rd_val = reload_q;
      default:    rd_val = ALL_ONES;
    endcase
  end

  always_comb begin
    ctrl1_d  = ctrl1_q;
    ctrl2_d  = ctrl2_q;
    smode_d  = smode_q;
    ien_d    = ien_q;
    flags_d  = flags_q;
    count_d  = count_q;
    presc_d  = presc_q;
    reload_d = reload_q;
    pcount_d = pcount_q;
    events_d = events_q;
    rdata_d  = '0;

    if (acc) begin
      case (func)
        FUNC_TICK: begin
          if (ctrl1_q[0]) begin
            // pcount+1 < presc+1 in 33 bits is just pcount < presc
            if (pcount_q < presc_q) begin
              pcount_d = pcount_q + 32'd1;
            end else begin
              pcount_d = '0;
              // count+1 > reload in 33 bits is count >= reload
              if (count_q >= reload_q) begin
                count_d              = '0;
                flags_d[FLAG_UPDATE] = 1'b1;
                events_d             = events_q + 32'd1;
              end else begin
                count_d = count_q + 32'd1;
              end
            end
          end
        end
        FUNC_READ: begin
          rdata_d = in_window ? rd_val : ALL_ONES;
        end
        FUNC_WRITE: begin
          if (in_window) begin
            case (offset)
              OFS_CTRL1:  ctrl1_d = wdata;
              OFS_CTRL2:  ctrl2_d = wdata;
              OFS_SMODE:  smode_d = wdata;
              OFS_IEN:    ien_d = wdata;
              OFS_STATUS: begin
                if (wdata[BUS_UPDATE_BIT])  flags_d[FLAG_UPDATE] = 1'b0;
                if (wdata[BUS_TRIGGER_BIT]) flags_d[FLAG_TRIGGER] = 1'b0;
              end
              OFS_EVGEN:  begin
                if (wdata[BUS_UPDATE_BIT])  flags_d[FLAG_UPDATE] = 1'b1;
                if (wdata[BUS_TRIGGER_BIT]) flags_d[FLAG_TRIGGER] = 1'b1;
              end
              OFS_COUNT:  count_d = wdata;
              OFS_PRESC:  presc_d = wdata;
              OFS_RELOAD: reload_d = wdata;
              default:    ;
            endcase
          end
        end
        default: ;  // unused code: no effect, zero read data
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q     <= '0;
      ctrl2_q     <= '0;
      smode_q     <= '0;
      ien_q       <= '0;
      flags_q     <= '0;
      count_q     <= '0;
      presc_q     <= '0;
      reload_q    <= '0;
      pcount_q    <= '0;
      events_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ctrl1_q  <= ctrl1_d;
      ctrl2_q  <= ctrl2_d;
      smode_q  <= smode_d;
      ien_q    <= ien_d;
      flags_q  <= flags_d;
      count_q  <= count_d;
      presc_q  <= presc_d;
      reload_q <= reload_d;
      pcount_q <= pcount_d;
      events_q <= events_d;
      if (acc) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with the post-item state
  always_ff @(posedge clk_i) begin
    if (acc) begin
      rdata_q <= rdata_d;
      irq_q   <= flags_d[FLAG_UPDATE] && ien_d[0];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.rdata         = rdata_q;
  assign out_o.irq_pending   = irq_q;
  assign out_o.update_events = events_q;

  // a stalled result must block new items
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("item taken while result is stalled");

  // state only moves with an accepted item
  a_events_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> $stable(events_q) && $stable(count_q) && $stable(pcount_q))
    else $error("timer state changed without an item");

  // a tick with the counter disabled leaves the counters alone
  a_disabled_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && func == FUNC_TICK && !ctrl1_q[0] |=>
      $stable(count_q) && $stable(pcount_q) && $stable(events_q))
    else $error("disabled counter advanced");

  // the event total moves by one at most, and only together with a counter wrap
  a_event_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && func == FUNC_TICK |=>
      (events_q == $past(events_q)) ||
      (events_q == $past(events_q) + 32'd1 && count_q == '0))
    else $error("bad update event step");

endmodule
